// ----- sv/bhed_pkg.sv -----
package bhed_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 1;
   localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 1'b0;
   localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

   localparam logic [7:0] BSLASH    = 8'h5C;
   localparam logic [7:0] CHAR_X_UP = 8'h58;
   localparam logic [7:0] CHAR_X_LO = 8'h78;
   localparam logic [7:0] CHAR_0    = 8'h30;
   localparam logic [7:0] CHAR_9    = 8'h39;
   localparam logic [7:0] CHAR_A_LO = 8'h61;
   localparam logic [7:0] CHAR_A_UP = 8'h41;
   localparam logic [7:0] HEX_LETTER_SPAN = 8'd5;

   typedef enum logic [1:0] {
      PH_NORMAL = 2'd0,
      PH_ESC    = 2'd1,
      PH_X      = 2'd2,
      PH_DIGIT  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_END  = 2'd1,
      KIND_OVF  = 2'd2
   } kind_type;

   // one queue entry: everything a single input word produces
   typedef struct packed {
      logic            ovf;
      logic            is_end;
      logic [2:0]      nbytes;
      logic [3:0][7:0] bytes;
      logic [15:0]     count;
   } entry_type;

   function automatic logic is_hex(input logic [7:0] c);
      logic ok;
      ok = (c inside {[CHAR_0:CHAR_9]})
         || (c inside {[CHAR_A_LO:CHAR_A_LO + HEX_LETTER_SPAN]})
         || (c inside {[CHAR_A_UP:CHAR_A_UP + HEX_LETTER_SPAN]});
      return ok;
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      if (c inside {[CHAR_0:CHAR_9]}) begin
         v = c - CHAR_0;
      end else if (c inside {[CHAR_A_LO:CHAR_A_LO + HEX_LETTER_SPAN]}) begin
         v = c - CHAR_A_LO + 8'd10;
      end else begin
         v = c - CHAR_A_UP + 8'd10;
      end
      return v[3:0];
   endfunction

endpackage

// ----- sv/bhed_front.sv -----
module bhed_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_in_byte,
   input  logic                req_msg_last,
   input  logic [15:0]         capacity,
   input  logic                q_full,
   output logic                push,
   output bhed_pkg::entry_type push_entry
);
   import bhed_pkg::*;

   phase_type       phase_ff, phase_in, phase_step;
   logic [7:0]      digit_ff, digit_in, digit_step;
   logic [15:0]     produced_ff, produced_in;
   logic            dropping_ff, dropping_in;
   logic [3:0][7:0] grp;
   logic [2:0]      n;
   logic [16:0]     sum;
   logic            ovf;
   logic            accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // escape scanner: what this word produces and where the scanner goes next
   always_comb begin
      grp        = '0;
      n          = 3'd0;
      phase_step = phase_ff;
      digit_step = digit_ff;
      case (phase_ff)
         PH_NORMAL: begin
            if (req_in_byte == BSLASH) begin
               phase_step = PH_ESC;
            end else begin
               grp[0] = req_in_byte;
               n      = 3'd1;
            end
         end
         PH_ESC: begin
            if (req_in_byte == BSLASH) begin
               grp[0]     = BSLASH;
               n          = 3'd1;
               phase_step = PH_NORMAL;
            end else if (req_in_byte == CHAR_X_UP || req_in_byte == CHAR_X_LO) begin
               phase_step = PH_X;
            end else begin
               grp[0]     = BSLASH;
               grp[1]     = req_in_byte;
               n          = 3'd2;
               phase_step = PH_NORMAL;
            end
         end
         PH_X: begin
            if (is_hex(req_in_byte)) begin
               digit_step = req_in_byte;
               phase_step = PH_DIGIT;
            end else begin
               grp[0]     = BSLASH;
               grp[1]     = CHAR_X_LO;
               grp[2]     = req_in_byte;
               n          = 3'd3;
               phase_step = PH_NORMAL;
            end
         end
         PH_DIGIT: begin
            if (is_hex(req_in_byte)) begin
               grp[0] = {hex_val(digit_ff), hex_val(req_in_byte)};
               n      = 3'd1;
            end else begin
               grp[0] = BSLASH;
               grp[1] = CHAR_X_LO;
               grp[2] = digit_ff;
               grp[3] = req_in_byte;
               n      = 3'd4;
            end
            phase_step = PH_NORMAL;
         end
         default: begin
            phase_step = PH_NORMAL;
         end
      endcase
   end

   assign sum = {1'b0, produced_ff} + 17'(n);
   assign ovf = (n != 3'd0) && (sum > {1'b0, capacity});

   always_comb begin
      phase_in    = phase_ff;
      digit_in    = digit_ff;
      produced_in = produced_ff;
      dropping_in = dropping_ff;
      push        = 1'b0;
      push_entry  = '0;
      if (accept) begin
         if (dropping_ff) begin
            if (req_msg_last) begin
               phase_in    = PH_NORMAL;
               digit_in    = '0;
               produced_in = '0;
               dropping_in = 1'b0;
            end
         end else if (ovf) begin
            push           = 1'b1;
            push_entry.ovf = 1'b1;
            phase_in       = PH_NORMAL;
            digit_in       = '0;
            if (req_msg_last) begin
               produced_in = '0;
            end else begin
               dropping_in = 1'b1;
            end
         end else begin
            push              = (n != 3'd0) || req_msg_last;
            push_entry.is_end = req_msg_last;
            push_entry.nbytes = n;
            push_entry.bytes  = grp;
            push_entry.count  = sum[15:0];
            if (req_msg_last) begin
               // a pending escape is simply discarded
               phase_in    = PH_NORMAL;
               digit_in    = '0;
               produced_in = '0;
            end else begin
               phase_in    = phase_step;
               digit_in    = digit_step;
               produced_in = sum[15:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_NORMAL;
         digit_ff    <= '0;
         produced_ff <= '0;
         dropping_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         digit_ff    <= digit_in;
         produced_ff <= produced_in;
         dropping_ff <= dropping_in;
      end
   end

endmodule

// ----- sv/bhed_queue.sv -----
module bhed_queue #(
   parameter int DEPTH = bhed_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bhed_pkg::entry_type push_entry,
   input  logic                pop,
   output bhed_pkg::entry_type head,
   output logic                full,
   output logic                empty
);
   import bhed_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_FULL);
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- sv/bhed_back.sv -----
module bhed_back (
   input  logic                clock,
   input  logic                reset,
   input  bhed_pkg::entry_type head,
   input  logic                empty,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_kind,
   output logic [7:0]          rsp_out_byte,
   output logic [15:0]         rsp_out_count,
   output logic                rsp_run_last
);
   import bhed_pkg::*;

   logic [2:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   kind_type    kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;
   logic [15:0] count_ff, count_in;
   logic        last_ff, last_in;
   logic [2:0]  total;
   logic        load;

   // results per entry: one for overflow, else the bytes plus an optional end
   assign total = head.ovf ? 3'd1 : head.nbytes + 3'(head.is_end);
   assign load  = !empty && (!valid_ff || rsp_ready);
   assign pop   = load && (idx_ff == total - 3'd1);

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      count_in = count_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         last_in  = pop;
         idx_in   = pop ? 3'd0 : idx_ff + 3'd1;
         if (head.ovf) begin
            kind_in  = KIND_OVF;
            byte_in  = '0;
            count_in = '0;
         end else if (idx_ff < head.nbytes) begin
            kind_in  = KIND_BYTE;
            byte_in  = head.bytes[idx_ff[1:0]];
            count_in = '0;
         end else begin
            kind_in  = KIND_END;
            byte_in  = '0;
            count_in = head.count;
         end
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      byte_ff  <= byte_in;
      count_ff <= count_in;
      last_ff  <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_out_count = count_ff;
   assign rsp_run_last  = last_ff;

endmodule

// ----- sv/backslash_hex_escape_decoder.sv -----
// Each input word that produces results goes into the entry queue as one entry; the results
// are then registered one by one in the output register.
// Throughput: one input word per cycle while the entry queue has room; results leave
// one per cycle while the receiver is ready, zero to five per input word.
// Reset (synchronous, active high) clears the scanner, message count, queue and output
// valid, and sets the capacity register to 65535.
module backslash_hex_escape_decoder #(
   parameter int QUEUE_DEPTH = bhed_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_in_byte,
   input  logic                            req_msg_last,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_kind,
   output logic [7:0]                      rsp_out_byte,
   output logic [15:0]                     rsp_out_count,
   output logic                            rsp_run_last,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bhed_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bhed_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bhed_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import bhed_pkg::*;

   logic [15:0]          capacity_ff, capacity_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 push, pop, q_full, q_empty;
   entry_type            push_entry, head;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_idx == REG_CAPACITY) begin
         capacity_in = csr_pwdata[15:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_idx == REG_CAPACITY) begin
         csr_prdata = CSR_DATA_W'(capacity_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   bhed_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .req_msg_last (req_msg_last),
      .capacity     (capacity_ff),
      .q_full       (q_full),
      .push         (push),
      .push_entry   (push_entry)
   );

   bhed_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (q_full),
      .empty      (q_empty)
   );

   bhed_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .empty         (q_empty),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_count (rsp_out_count),
      .rsp_run_last  (rsp_run_last)
   );

endmodule

// ----- sv/bhed_checker.sv -----
module bhed_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_out_byte,
   input logic [15:0] rsp_out_count,
   input logic        rsp_run_last
);
   import bhed_pkg::*;

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_out_byte) && $stable(rsp_out_count) && $stable(rsp_run_last))
      else $error("result word changed while stalled");

   // end and overflow always close the run of an input word
   a_tail_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_END || rsp_kind == KIND_OVF) |-> rsp_run_last)
      else $error("end or overflow word not marked last");

   a_byte_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_BYTE |-> rsp_out_count == 16'd0)
      else $error("byte word carries a count");

   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_OVF |-> rsp_out_byte == 8'd0 && rsp_out_count == 16'd0)
      else $error("overflow word carries data");

endmodule

bind backslash_hex_escape_decoder bhed_checker u_bhed_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_kind      (rsp_kind),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_out_count (rsp_out_count),
   .rsp_run_last  (rsp_run_last)
);

// ----- sim/backslash_hex_escape_decoder_tb.sv -----
module backslash_hex_escape_decoder_tb;
   import bhed_pkg::*;

   localparam int PERIOD       = 12;
   localparam int RESET_CYCLES = 8;
   localparam int DRAIN_CYCLES = 8;
   localparam int IDLE_PCT     = 6;
   localparam int HOLD_CYCLES  = 80;
   localparam int CYCLE_LIMIT  = 200000;
   localparam logic [4:0] NOT_HEX = 5'd16;
   localparam logic [CSR_ADDR_W-1:0] CAP_ADDR = CSR_ADDR_W'(4 * REG_CAPACITY);

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic [15:0] count;
      logic        run_last;
   } result_word_type;

   typedef struct packed {
      logic        set_cap;
      logic [15:0] cap;
      logic [7:0]  in_byte;
      logic        last;
      logic        pinned;
      kind_type    kind;
      logic [7:0]  out_byte;
      logic [15:0] out_count;
   } script_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [7:0]            req_in_byte;
   logic                  req_msg_last;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [1:0]            rsp_kind;
   logic [7:0]            rsp_out_byte;
   logic [15:0]           rsp_out_count;
   logic                  rsp_run_last;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // decoder state as predicted
   phase_type   esc_phase;
   logic [7:0]  first_hex;
   logic [15:0] made_count;
   logic        drop_rest;
   logic [15:0] cap_limit;

   result_word_type expected_words[$];
   int          fail_count   = 0;
   int          words_sent   = 0;
   int          cycle_count  = 0;
   int          idle_pct     = IDLE_PCT;
   int          stalls_asked = 0;
   int          stalls_taken = 0;
   int          stall_left   = 0;

   // directed words; the pinned result is the last one the word causes
   script_row_type script [31] = '{
      '{1'b0, 16'd0, 8'h00, 1'b0, 1'b1, KIND_BYTE, 8'h00, 16'd0},
      '{1'b0, 16'd0, 8'hFF, 1'b0, 1'b1, KIND_BYTE, 8'hFF, 16'd0},
      '{1'b0, 16'd0, 8'h5C, 1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
      '{1'b0, 16'd0, 8'h5C, 1'b0, 1'b1, KIND_BYTE, 8'h5C, 16'd0},
      '{1'b0, 16'd0, 8'h5C, 1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
      '{1'b0, 16'd0, 8'h78, 1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
      '{1'b0, 16'd0, 8'h66, 1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
      '{1'b0, 16'd0, 8'h46, 1'b0, 1'b1, KIND_BYTE, 8'hFF, 16'd0},
      '{1'b0, 16'd0, 8'h5C, 1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
      '{1'b0, 16'd0, 8'h58, 1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
      '{1'b0, 16'd0, 8'h47, 1'b0, 1'b1, KIND_BYTE, 8'h47, 16'd0},
      '{1'b0, 16'd0, 8'h5C, 1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
      '{1'b0, 16'd0, 8'h21, 1'b1, 1'b1, KIND_END,  8'h00, 16'd9},
      '{1'b0, 16'd0, 8'h5C, 1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
      '{1'b0, 16'd0, 8'h78, 1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
      '{1'b0, 16'd0, 8'h39, 1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
      '{1'b0, 16'd0, 8'h68, 1'b0, 1'b1, KIND_BYTE, 8'h68, 16'd0},
      '{1'b0, 16'd0, 8'h5C, 1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
      '{1'b0, 16'd0, 8'h78, 1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
      '{1'b0, 16'd0, 8'h61, 1'b1, 1'b1, KIND_END,  8'h00, 16'd4},
      '{1'b1, 16'd1, 8'h00, 1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
      '{1'b0, 16'd0, 8'h41, 1'b0, 1'b1, KIND_BYTE, 8'h41, 16'd0},
      '{1'b0, 16'd0, 8'h42, 1'b0, 1'b1, KIND_OVF,  8'h00, 16'd0},
      '{1'b0, 16'd0, 8'h43, 1'b1, 1'b0, KIND_BYTE, 8'h00, 16'd0},
      '{1'b0, 16'd0, 8'h5C, 1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
      '{1'b0, 16'd0, 8'h78, 1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
      '{1'b0, 16'd0, 8'h41, 1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
      '{1'b0, 16'd0, 8'h47, 1'b1, 1'b1, KIND_OVF,  8'h00, 16'd0},
      '{1'b1, 16'd0, 8'h00, 1'b0, 1'b0, KIND_BYTE, 8'h00, 16'd0},
      '{1'b0, 16'd0, 8'h5A, 1'b1, 1'b1, KIND_OVF,  8'h00, 16'd0},
      '{1'b0, 16'd0, 8'h5C, 1'b1, 1'b1, KIND_END,  8'h00, 16'd0}
   };

   backslash_hex_escape_decoder dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_byte   (req_in_byte),
      .req_msg_last  (req_msg_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_count (rsp_out_count),
      .rsp_run_last  (rsp_run_last),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always #(PERIOD / 2) clock = ~clock;

   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      if (c >= CHAR_0 && c <= CHAR_9) return 5'(c - CHAR_0);
      if (c >= CHAR_A_LO && c <= CHAR_A_LO + 8'd5) return 5'(c - CHAR_A_LO + 8'd10);
      if (c >= CHAR_A_UP && c <= CHAR_A_UP + 8'd5) return 5'(c - CHAR_A_UP + 8'd10);
      return NOT_HEX;
   endfunction

   function automatic logic [7:0] random_hex_char();
      case ($urandom_range(2))
         0: return CHAR_0 + 8'($urandom_range(9));
         1: return CHAR_A_LO + 8'($urandom_range(5));
         default: return CHAR_A_UP + 8'($urandom_range(5));
      endcase
   endfunction

   function automatic logic [7:0] random_x_char();
      return $urandom_range(1) ? CHAR_X_LO : CHAR_X_UP;
   endfunction

   task automatic clear_message();
      esc_phase  = PH_NORMAL;
      first_hex  = 8'd0;
      made_count = 16'd0;
      drop_rest  = 1'b0;
   endtask

   // Works out the words one input byte causes and queues them.
   task automatic decode_step(input logic [7:0] b, input logic last, input logic pinned,
                              input result_word_type pin);
      logic [7:0] grp [4];
      result_word_type outs [5];
      logic [4:0] hi;
      logic [4:0] lo;
      int n;
      int k;
      n = 0;
      k = 0;
      lo = nibble_of(b);
      hi = nibble_of(first_hex);
      if (drop_rest) begin
         if (last) clear_message();
      end else begin
         case (esc_phase)
            PH_NORMAL: begin
               if (b == BSLASH) begin
                  esc_phase = PH_ESC;
               end else begin
                  grp[0] = b;
                  n = 1;
               end
            end
            PH_ESC: begin
               if (b == BSLASH) begin
                  grp[0] = BSLASH;
                  n = 1;
                  esc_phase = PH_NORMAL;
               end else if (b == CHAR_X_UP || b == CHAR_X_LO) begin
                  esc_phase = PH_X;
               end else begin
                  grp[0] = BSLASH;
                  grp[1] = b;
                  n = 2;
                  esc_phase = PH_NORMAL;
               end
            end
            PH_X: begin
               if (lo != NOT_HEX) begin
                  first_hex = b;
                  esc_phase = PH_DIGIT;
               end else begin
                  grp[0] = BSLASH;
                  grp[1] = CHAR_X_LO;
                  grp[2] = b;
                  n = 3;
                  esc_phase = PH_NORMAL;
               end
            end
            default: begin
               if (lo != NOT_HEX) begin
                  grp[0] = {hi[3:0], lo[3:0]};
                  n = 1;
               end else begin
                  grp[0] = BSLASH;
                  grp[1] = CHAR_X_LO;
                  grp[2] = first_hex;
                  grp[3] = b;
                  n = 4;
               end
               esc_phase = PH_NORMAL;
            end
         endcase

         // the whole group must fit, or none of it goes out
         if (n > 0 && int'(made_count) + n > int'(cap_limit)) begin
            outs[0] = '{KIND_OVF, 8'd0, 16'd0, 1'b0};
            k = 1;
            if (last) begin
               clear_message();
            end else begin
               esc_phase = PH_NORMAL;
               first_hex = 8'd0;
               drop_rest = 1'b1;
            end
         end else begin
            for (int i = 0; i < n; i++) begin
               outs[k] = '{KIND_BYTE, grp[i], 16'd0, 1'b0};
               k++;
            end
            made_count = made_count + 16'(n);
            if (last) begin
               outs[k] = '{KIND_END, 8'd0, made_count, 1'b0};
               k++;
               clear_message();
            end
         end
      end

      if (k > 0) begin
         outs[k-1].run_last = 1'b1;
         if (pinned) begin
            outs[k-1].kind  = pin.kind;
            outs[k-1].data  = pin.data;
            outs[k-1].count = pin.count;
         end
      end
      for (int i = 0; i < k; i++) expected_words.push_back(outs[i]);
   endtask

   task automatic send_word(input logic [7:0] b, input logic last, input logic pinned,
                            input result_word_type pin);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_in_byte  <= b;
      req_msg_last <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_step(b, last, pinned, pin);
      words_sent++;
   endtask

   // Random message: a mix of well-formed escapes, broken ones and raw noise.
   task automatic send_message();
      logic [7:0] msg[$];
      int tokens;
      tokens = $urandom_range(1, 8);
      for (int t = 0; t < tokens; t++) begin
         case ($urandom_range(9))
            0, 1, 2: msg.push_back(8'($urandom_range(255)));
            3: begin
               msg.push_back(BSLASH);
               msg.push_back(BSLASH);
            end
            4, 5: begin
               msg.push_back(BSLASH);
               msg.push_back(random_x_char());
               msg.push_back(random_hex_char());
               msg.push_back(random_hex_char());
            end
            6: begin
               msg.push_back(BSLASH);
               msg.push_back(8'($urandom_range(255)));
            end
            7: begin
               msg.push_back(BSLASH);
               msg.push_back(random_x_char());
               msg.push_back(8'($urandom_range(255)));
            end
            8: begin
               msg.push_back(BSLASH);
               msg.push_back(random_x_char());
               msg.push_back(random_hex_char());
               msg.push_back(8'($urandom_range(255)));
            end
            default: begin
               // an escape cut short, only sensible at the tail
               if (t == tokens - 1) begin
                  msg.push_back(BSLASH);
                  if ($urandom_range(2) != 0) msg.push_back(random_x_char());
                  if ($urandom_range(1) != 0) msg.push_back(random_hex_char());
               end else begin
                  msg.push_back(8'($urandom_range(255)));
               end
            end
         endcase
      end
      foreach (msg[i]) begin
         send_word(msg[i], i == msg.size() - 1, 1'b0, '{KIND_BYTE, 8'd0, 16'd0, 1'b0});
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CAP_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      cap_limit = value;
      // straight into a read-back
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[15:0] !== value) begin
         $error("out_capacity: expected %0d, got %0d", value, csr_prdata[15:0]);
         fail_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // receiver: random back-pressure, plus one long hold when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stalls_taken != stalls_asked) begin
         stalls_taken <= stalls_asked;
         stall_left   <= HOLD_CYCLES;
         rsp_ready    <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      result_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $error("word with nothing expected: kind %0d byte %0h count %0d",
                   rsp_kind, rsp_out_byte, rsp_out_count);
            fail_count++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
               fail_count++;
            end
            if (rsp_out_byte !== want.data) begin
               $error("out_byte: expected %0h, got %0h", want.data, rsp_out_byte);
               fail_count++;
            end
            if (rsp_out_count !== want.count) begin
               $error("out_count: expected %0d, got %0d", want.count, rsp_out_count);
               fail_count++;
            end
            if (rsp_run_last !== want.run_last) begin
               $error("run_last: expected %0d, got %0d", want.run_last, rsp_run_last);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int phase_end;
      logic [15:0] cap;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_in_byte  = 8'd0;
      req_msg_last = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      cap_limit    = CAPACITY_RESET;
      clear_message();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].set_cap) begin
            wait_drained();
            write_capacity(script[i].cap);
         end else begin
            send_word(script[i].in_byte, script[i].last, script[i].pinned,
                      '{script[i].kind, script[i].out_byte, script[i].out_count, 1'b1});
         end
      end

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: cap = 16'hFFFF;
            1: cap = 16'd1;
            2: cap = 16'($urandom_range(2, 6));
            3: cap = 16'($urandom_range(4, 24));
            4: cap = 16'd0;
            default: cap = 16'($urandom_range(1, 65535));
         endcase
         wait_drained();
         write_capacity(cap);
         idle_pct <= (ph == 3) ? 0 : IDLE_PCT;
         // long output hold while input keeps coming, fills the block up
         if (ph == 0) stalls_asked <= stalls_asked + 1;
         phase_end = words_sent + ((ph == 4) ? 25 : 80);
         while (words_sent < phase_end) send_message();
      end

      wait_drained();
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
